[rtl/min_of_window_max_gap_macros.svh]
// ----------------------------------------------------------------------------
// min_of_window_max_gap_macros
// assertion macros for the min of window max gap block
// ----------------------------------------------------------------------------
`ifndef MIN_OF_WINDOW_MAX_GAP_MACROS_SVH
`define MIN_OF_WINDOW_MAX_GAP_MACROS_SVH

// same-cycle implication
`define MWG_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MWG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/mwg_pkg.sv]
// ----------------------------------------------------------------------------
// mwg_pkg
// shared types and constants of the min of window max gap block
// ----------------------------------------------------------------------------
package mwg_pkg;

    localparam int MAX_WINDOW = 1024;
    localparam int COUNT_BITS = 20;
    localparam int VAL_W      = 31;
    localparam int WIN_W      = 11;
    localparam int HEAD_W     = $clog2(MAX_WINDOW);
    localparam int LEN_W      = HEAD_W + 1;
    localparam int POS_W      = $clog2(MAX_WINDOW + 1);
    localparam int OPQ_DEPTH  = 2;

    localparam logic [VAL_W-1:0] VAL_ALL_ONES = '1;
    localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(1);

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    last;
    } in_beat_t;

    typedef struct packed {
        logic [VAL_W-1:0] min_max_gap;
        logic             too_short;
    } out_beat_t;

    typedef struct packed {
        logic             has_gap;
        logic [VAL_W-1:0] gap;
        logic             last;
    } op_t;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] gap;
    } dq_entry_t;

    typedef struct packed {
        logic             result_load;
        logic [LEN_W-1:0] len;
    } back_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FRONT,
        ST_BACK,
        ST_DONE
    } back_state_t;

endpackage

[rtl/min_of_window_max_gap.sv]
// ----------------------------------------------------------------------------
// min_of_window_max_gap
// least over all windows of the largest gap in a nondecreasing value stream
//
//   channel   handshake        payload
//   input     push / full      item   (value, last)
//   result    pop / empty      result (min_max_gap, too_short)
//   config    cfg_we           cfg_wdata (window_gaps)
//
// the first value of a sequence passes only the idle state; later values
// pass idle, front and back, where front and back repeat while a deque
// entry drops at that end. a last beat then loads the result register in
// the done state. reset needs no clearing pass. a full result register
// stalls the engine, and the op queue then fills and raises full.
// ----------------------------------------------------------------------------
`include "min_of_window_max_gap_macros.svh"

module min_of_window_max_gap
    import mwg_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [WIN_W-1:0] cfg_wdata,
    input  logic             push,
    output logic             full,
    input  in_beat_t         item,
    output logic             empty,
    input  logic             pop,
    output out_beat_t        result
);

    logic         op_push;
    op_t          op_wdata;
    logic         op_full;
    logic         op_valid;
    logic         op_ready;
    op_t          op_rdata;
    back_status_t status;

    mwg_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .item     (item),
        .op_push  (op_push),
        .op_wdata (op_wdata),
        .op_full  (op_full)
    );

    mwg_op_fifo u_op_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (op_push),
        .wdata    (op_wdata),
        .full     (op_full),
        .rd_valid (op_valid),
        .rd_ready (op_ready),
        .rdata    (op_rdata)
    );

    mwg_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .op_valid  (op_valid),
        .op_ready  (op_ready),
        .op        (op_rdata),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .status    (status)
    );

    `MWG_ASSERT_SAME(a_deque_in_bounds, 1'b1, status.len <= LEN_W'(MAX_WINDOW), "deque overfilled")
    `MWG_ASSERT_NEXT(a_clear_after_result, status.result_load, status.len == '0, "deque not cleared")
    `MWG_ASSERT_SAME(a_result_from_engine, $fell(empty), $past(status.result_load), "stray result beat")

endmodule

[rtl/mwg_front.sv]
// ----------------------------------------------------------------------------
// mwg_front
// input side: takes a beat, forms the gap to the previous value, queues an op
// ----------------------------------------------------------------------------
module mwg_front
    import mwg_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    output logic     full,
    input  in_beat_t item,
    output logic     op_push,
    output op_t      op_wdata,
    input  logic     op_full
);

    logic signed [VAL_W-1:0] prev_value_reg;
    logic                    have_prev_reg;
    logic                    have_prev_next;
    logic signed [VAL_W:0]   diff;
    logic [VAL_W-1:0]        gap;

    assign full    = op_full;
    assign op_push = push && !op_full;

    assign diff = $signed({item.value[VAL_W-1], item.value})
                - $signed({prev_value_reg[VAL_W-1], prev_value_reg});

    // a falling step counts as no gap
    assign gap = diff[VAL_W] ? '0 : diff[VAL_W-1:0];

    always_comb
    begin
        op_wdata.has_gap = have_prev_reg;
        op_wdata.gap     = gap;
        op_wdata.last    = item.last;
        have_prev_next   = have_prev_reg;
        if (op_push)
        begin
            have_prev_next = !item.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_prev_reg <= 1'b0;
        end
        else
        begin
            have_prev_reg <= have_prev_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (op_push)
        begin
            prev_value_reg <= item.value;
        end
    end

endmodule

[rtl/mwg_op_fifo.sv]
// ----------------------------------------------------------------------------
// mwg_op_fifo
// short queue of ops between the input side and the deque engine
// ----------------------------------------------------------------------------
module mwg_op_fifo
    import mwg_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  op_t  wdata,
    output logic full,
    output logic rd_valid,
    input  logic rd_ready,
    output op_t  rdata
);

    localparam int PTR_W = (OPQ_DEPTH > 1) ? $clog2(OPQ_DEPTH) : 1;
    localparam int CNT_W = $clog2(OPQ_DEPTH + 1);

    op_t              slots_reg [OPQ_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_wr;
    logic             do_rd;

    assign full     = (count_reg == CNT_W'(OPQ_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rdata    = slots_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_ready && rd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(OPQ_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(OPQ_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slots_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

[rtl/mwg_back.sv]
// ----------------------------------------------------------------------------
// mwg_back
// deque engine: window maxima in a monotonic deque, least maximum, result beat
// ----------------------------------------------------------------------------
module mwg_back
    import mwg_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [WIN_W-1:0] cfg_wdata,
    input  logic             op_valid,
    output logic             op_ready,
    input  op_t              op,
    output logic             empty,
    input  logic             pop,
    output out_beat_t        result,
    output back_status_t     status
);

    function automatic logic [HEAD_W-1:0] slot(input logic [HEAD_W-1:0] base,
                                               input logic [HEAD_W-1:0] off);
        logic [HEAD_W:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= LEN_W'(MAX_WINDOW))
        begin
            sum = sum - LEN_W'(MAX_WINDOW);
        end
        return sum[HEAD_W-1:0];
    endfunction

    dq_entry_t               mem [MAX_WINDOW];
    dq_entry_t               rd_front_reg;
    dq_entry_t               rd_back_reg;
    logic                    mem_we;
    logic [HEAD_W-1:0]       wr_addr;
    dq_entry_t               wr_data;
    logic [HEAD_W-1:0]       rd_front_addr;
    logic [HEAD_W-1:0]       rd_back_addr;

    back_state_t             state_reg;
    back_state_t             state_next;
    logic [WIN_W-1:0]        window_reg;
    logic [WIN_W-1:0]        window_next;
    op_t                     op_reg;
    op_t                     op_next;
    logic [HEAD_W-1:0]       head_reg;
    logic [HEAD_W-1:0]       head_next;
    logic [LEN_W-1:0]        len_reg;
    logic [LEN_W-1:0]        len_next;
    logic [POS_W-1:0]        pos_reg;
    logic [POS_W-1:0]        pos_next;
    logic [COUNT_BITS-1:0]   count_reg;
    logic [COUNT_BITS-1:0]   count_next;
    logic [VAL_W-1:0]        best_reg;
    logic [VAL_W-1:0]        best_next;
    logic                    res_valid_reg;
    logic                    res_valid_next;
    out_beat_t               res_reg;
    out_beat_t               res_next;
    logic                    result_load;

    logic [POS_W-1:0]        w_eff;
    logic [POS_W-1:0]        front_age;
    logic                    front_expired;
    logic                    back_pop;
    logic [COUNT_BITS-1:0]   count_inc;
    logic [VAL_W-1:0]        front_gap_after;
    logic                    short_seq;

    // zero acts as one, above the deque size acts as the deque size
    always_comb
    begin
        if (window_reg == '0)
        begin
            w_eff = POS_W'(1);
        end
        else if (32'(window_reg) > 32'(MAX_WINDOW))
        begin
            w_eff = POS_W'(MAX_WINDOW);
        end
        else
        begin
            w_eff = POS_W'(window_reg);
        end
    end

    assign front_age       = pos_reg - rd_front_reg.pos;
    assign front_expired   = (len_reg != '0) && (front_age >= w_eff);
    assign back_pop        = (len_reg != '0) && (rd_back_reg.gap <= op_reg.gap);
    assign count_inc       = (count_reg == '1) ? count_reg : count_reg + 1'b1;
    assign front_gap_after = (len_reg == '0) ? op_reg.gap : rd_front_reg.gap;
    assign short_seq       = 32'(count_reg) < 32'(w_eff);

    always_comb
    begin
        state_next     = state_reg;
        window_next    = cfg_we ? cfg_wdata : window_reg;
        op_next        = op_reg;
        head_next      = head_reg;
        len_next       = len_reg;
        pos_next       = pos_reg;
        count_next     = count_reg;
        best_next      = best_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && !pop;
        result_load    = 1'b0;
        op_ready       = 1'b0;
        mem_we         = 1'b0;
        wr_addr        = slot(head_reg, len_reg[HEAD_W-1:0]);
        wr_data.pos    = pos_reg;
        wr_data.gap    = op_reg.gap;

        unique case (state_reg)
            ST_IDLE:
            begin
                op_ready = 1'b1;
                if (op_valid)
                begin
                    op_next = op;
                    if (op.has_gap)
                    begin
                        state_next = ST_FRONT;
                    end
                    else if (op.last)
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_FRONT:
            begin
                if (front_expired)
                begin
                    head_next = slot(head_reg, HEAD_W'(1));
                    len_next  = len_reg - 1'b1;
                end
                else
                begin
                    state_next = ST_BACK;
                end
            end
            ST_BACK:
            begin
                if (back_pop)
                begin
                    len_next = len_reg - 1'b1;
                end
                else
                begin
                    mem_we     = 1'b1;
                    len_next   = len_reg + 1'b1;
                    pos_next   = pos_reg + 1'b1;
                    count_next = count_inc;
                    if ((32'(count_inc) >= 32'(w_eff)) && (front_gap_after < best_reg))
                    begin
                        best_next = front_gap_after;
                    end
                    state_next = op_reg.last ? ST_DONE : ST_IDLE;
                end
            end
            ST_DONE:
            begin
                if (!res_valid_reg || pop)
                begin
                    result_load          = 1'b1;
                    res_valid_next       = 1'b1;
                    res_next.min_max_gap = short_seq ? VAL_ALL_ONES : best_reg;
                    res_next.too_short   = short_seq;
                    head_next            = '0;
                    len_next             = '0;
                    pos_next             = '0;
                    count_next           = '0;
                    best_next            = VAL_ALL_ONES;
                    state_next           = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // reads follow the next head and length so the registered data is current in the next cycle
    assign rd_front_addr = head_next;
    assign rd_back_addr  = slot(head_next, len_next[HEAD_W-1:0] - 1'b1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            window_reg    <= WINDOW_RESET;
            head_reg      <= '0;
            len_reg       <= '0;
            pos_reg       <= '0;
            count_reg     <= '0;
            best_reg      <= VAL_ALL_ONES;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            window_reg    <= window_next;
            head_reg      <= head_next;
            len_reg       <= len_next;
            pos_reg       <= pos_next;
            count_reg     <= count_next;
            best_reg      <= best_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        res_reg <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_front_reg <= mem[rd_front_addr];
        rd_back_reg  <= mem[rd_back_addr];
    end

    assign empty              = !res_valid_reg;
    assign result             = res_reg;
    assign status.result_load = result_load;
    assign status.len         = len_reg;

endmodule

[tb/sv/tb_min_of_window_max_gap.sv]
// ----------------------------------------------------------------------------
// tb_min_of_window_max_gap
// self-checking bench for the min of window max gap block
//
// a directed table covers single-element sequences, full-range and decreasing
// steps, window zero and windows past the maximum. random phases follow, each
// with its own window setting and idling mix, and feed mostly nondecreasing
// sequences with some noise. every input beat goes through a behavioral
// predictor; result beats are compared in order against the predicted queue.
// one phase holds pop low for a long stretch so the block backs up to full.
// ----------------------------------------------------------------------------
module tb_min_of_window_max_gap;
    import mwg_pkg::*;

    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 6;
    localparam int DRAIN_CYCLES   = 1100;
    localparam int END_CYCLES     = 2200;
    localparam int WATCHDOG_LIMIT = 30000;
    localparam int HOLD_CYCLES    = 400;
    localparam int MAX_PRINTS     = 100;
    localparam int N_DIRECTED     = 21;
    localparam int N_PHASES       = 13;

    localparam int VALUE_MIN = -(2 ** (VAL_W - 1));
    localparam int VALUE_MAX = (2 ** (VAL_W - 1)) - 1;
    localparam int unsigned GAP_COUNT_MAX = int'((64'd1 << COUNT_BITS) - 1);

    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } idle_mode_t;

    typedef struct {
        int unsigned pos;
        int unsigned gap;
    } gap_slot_t;

    typedef struct {
        int               win;
        int               value;
        logic             last;
        bit               typed;
        logic [VAL_W-1:0] exp_gap;
        bit               exp_short;
    } step_row_t;

    typedef struct {
        int         win;
        idle_mode_t mode;
        int         items;
        bit         hold;
    } phase_t;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             cfg_we    = 1'b0;
    logic [WIN_W-1:0] cfg_wdata = '0;
    logic             push      = 1'b0;
    logic             full;
    in_beat_t         item      = '0;
    logic             empty;
    logic             pop       = 1'b0;
    out_beat_t        result;

    idle_mode_t idle_mode       = IDLE_NONE;
    int         hold_left       = 0;
    int         mismatch_count  = 0;
    int         quiet_cycles    = 0;

    // predictor state
    logic [WIN_W-1:0] win_reg = WINDOW_RESET;
    longint           prev_val;
    bit               have_prev;
    int unsigned      gap_cnt;
    int unsigned      cur_pos;
    int unsigned      best_gap;
    gap_slot_t        window_max_q[$];
    out_beat_t        pending_results[$];

    step_row_t directed_rows [N_DIRECTED] = '{
        '{-1, 5,         1'b1, 1'b1, VAL_ALL_ONES, 1'b1},
        '{-1, VALUE_MIN, 1'b0, 1'b0, '0,           1'b0},
        '{-1, VALUE_MAX, 1'b1, 1'b1, VAL_ALL_ONES, 1'b0},
        '{-1, 100,       1'b0, 1'b0, '0,           1'b0},
        '{-1, 50,        1'b1, 1'b1, '0,           1'b0},
        '{-1, 0,         1'b0, 1'b0, '0,           1'b0},
        '{-1, 3,         1'b0, 1'b0, '0,           1'b0},
        '{-1, 10,        1'b0, 1'b0, '0,           1'b0},
        '{-1, 11,        1'b1, 1'b1, 31'd1,        1'b0},
        '{-1, -10,       1'b0, 1'b0, '0,           1'b0},
        '{-1, -4,        1'b0, 1'b0, '0,           1'b0},
        '{-1, -1,        1'b1, 1'b1, 31'd3,        1'b0},
        '{0,  20,        1'b0, 1'b0, '0,           1'b0},
        '{-1, 27,        1'b1, 1'b1, 31'd7,        1'b0},
        '{2047, 1,       1'b0, 1'b0, '0,           1'b0},
        '{-1, 2,         1'b1, 1'b1, VAL_ALL_ONES, 1'b1},
        '{3,  0,         1'b0, 1'b0, '0,           1'b0},
        '{-1, 5,         1'b0, 1'b0, '0,           1'b0},
        '{-1, 6,         1'b0, 1'b0, '0,           1'b0},
        '{-1, 20,        1'b0, 1'b0, '0,           1'b0},
        '{-1, 21,        1'b1, 1'b0, '0,           1'b0}
    };

    // win of -1 picks a random small window
    phase_t phases [N_PHASES] = '{
        '{1,    IDLE_NONE, 60,   1'b0},
        '{2,    IDLE_SEND, 60,   1'b0},
        '{0,    IDLE_RECV, 60,   1'b0},
        '{3,    IDLE_BOTH, 60,   1'b0},
        '{1,    IDLE_NONE, 60,   1'b1},
        '{2047, IDLE_NONE, 1050, 1'b0},
        '{1025, IDLE_SEND, 20,   1'b0},
        '{1024, IDLE_RECV, 20,   1'b0},
        '{5,    IDLE_BOTH, 60,   1'b0},
        '{8,    IDLE_NONE, 60,   1'b0},
        '{-1,   IDLE_SEND, 60,   1'b0},
        '{4,    IDLE_RECV, 60,   1'b0},
        '{6,    IDLE_BOTH, 60,   1'b0}
    };

    min_of_window_max_gap i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    function automatic int unsigned eff_window();
        if (win_reg == '0)
        begin
            return 1;
        end
        if (win_reg > MAX_WINDOW)
        begin
            return MAX_WINDOW;
        end
        return int'(win_reg);
    endfunction

    function automatic void clear_sequence_state();
        prev_val  = 0;
        have_prev = 1'b0;
        gap_cnt   = 0;
        cur_pos   = 0;
        window_max_q.delete();
        best_gap  = 32'(VAL_ALL_ONES);
    endfunction

    function automatic void take_gap(input int unsigned g);
        int unsigned we;
        gap_slot_t   s;
        we = eff_window();
        // expire from the front, then drop dominated gaps from the back
        while (window_max_q.size() > 0 && cur_pos - window_max_q[0].pos >= we)
        begin
            void'(window_max_q.pop_front());
        end
        while (window_max_q.size() > 0 && window_max_q[$].gap <= g)
        begin
            void'(window_max_q.pop_back());
        end
        if (window_max_q.size() < MAX_WINDOW)
        begin
            s.pos = cur_pos;
            s.gap = g;
            window_max_q.insert(window_max_q.size(), s);
        end
        cur_pos++;
        if (gap_cnt < GAP_COUNT_MAX)
        begin
            gap_cnt++;
        end
        if (gap_cnt >= we && window_max_q[0].gap < best_gap)
        begin
            best_gap = window_max_q[0].gap;
        end
    endfunction

    function automatic bit predict_min_gap(input in_beat_t b, output out_beat_t res);
        longint v;
        longint d;
        bit     short_seq;
        v   = longint'($signed(b.value));
        res = '0;
        if (have_prev)
        begin
            d = v - prev_val;
            if (d < 0)
            begin
                d = 0;
            end
            take_gap(int'(d[VAL_W-1:0]));
        end
        prev_val  = v;
        have_prev = 1'b1;
        if (!b.last)
        begin
            return 1'b0;
        end
        short_seq = gap_cnt < eff_window();
        res.min_max_gap = short_seq ? VAL_ALL_ONES : best_gap[VAL_W-1:0];
        res.too_short   = short_seq;
        clear_sequence_state();
        return 1'b1;
    endfunction

    function automatic int send_idle_pct();
        case (idle_mode)
            IDLE_SEND: return 74;
            IDLE_BOTH: return 18;
            default:   return 0;
        endcase
    endfunction

    function automatic int recv_stall_pct();
        case (idle_mode)
            IDLE_RECV: return 74;
            IDLE_BOTH: return 18;
            default:   return 0;
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS)
        begin
            $display("%0t mismatch: %s", $time, msg);
        end
    endtask

    task automatic send_beat(input logic signed [VAL_W-1:0] v, input logic lst,
                             input bit typed, input out_beat_t typed_res);
        in_beat_t  b;
        out_beat_t predicted;
        while ($urandom_range(0, 99) < send_idle_pct())
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        b.value = v;
        b.last  = lst;
        push <= 1'b1;
        item <= b;
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
        if (predict_min_gap(b, predicted))
        begin
            pending_results.insert(pending_results.size(), typed ? typed_res : predicted);
        end
    endtask

    task automatic write_window(input logic [WIN_W-1:0] w);
        push <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= w;
        @(posedge clk);
        cfg_we  <= 1'b0;
        win_reg = w;
    endtask

    function automatic int pick_gaps(input int unsigned we, input int room);
        if (we > 64)
        begin
            return (room > int'(we)) ? int'(we + $urandom_range(0, 8))
                                     : int'($urandom_range(0, 8));
        end
        if ($urandom_range(0, 4) == 0)
        begin
            return int'($urandom_range(0, we - 1));
        end
        return int'(we + $urandom_range(0, we + 6));
    endfunction

    task automatic run_sequence(input int n_gaps);
        longint                  v;
        longint                  step_sz;
        logic signed [VAL_W-1:0] raw;
        int                      r;
        out_beat_t               none;
        none = '0;
        r    = $urandom_range(0, 9);
        if (r < 4)
        begin
            raw = VAL_W'($urandom);
            v   = longint'(raw);
        end
        else if (r == 4)
        begin
            v = longint'(VALUE_MIN);
        end
        else
        begin
            v = longint'($urandom_range(0, 2000)) - 1000;
        end
        for (int i = 0; i <= n_gaps; i++)
        begin
            send_beat(v[VAL_W-1:0], i == n_gaps, 1'b0, none);
            r = $urandom_range(0, 99);
            if (r < 30)
                step_sz = $urandom_range(0, 3);
            else if (r < 60)
                step_sz = $urandom_range(0, 255);
            else if (r < 80)
                step_sz = $urandom_range(0, 1 << 20);
            else if (r < 88)
                step_sz = $urandom;
            else if (r < 94)
                step_sz = 0;
            else
                step_sz = -longint'($urandom_range(1, 1000));
            v = v + step_sz;
            if (v > VALUE_MAX)
            begin
                v = longint'(VALUE_MAX);
            end
            if (v < VALUE_MIN)
            begin
                v = longint'(VALUE_MIN);
            end
        end
    endtask

    // result side: random stalls plus the long hold-off
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                pop <= 1'b0;
                hold_left--;
            end
            else
            begin
                pop <= ($urandom_range(0, 99) >= recv_stall_pct());
            end
        end
    end

    always @(posedge clk)
    begin
        out_beat_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result beat gap %0d short %0b",
                                          result.min_max_gap, result.too_short));
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.min_max_gap !== want.min_max_gap)
                begin
                    report_mismatch($sformatf("min_max_gap %0d, want %0d",
                                              result.min_max_gap, want.min_max_gap));
                end
                if (result.too_short !== want.too_short)
                begin
                    report_mismatch($sformatf("too_short %0b, want %0b",
                                              result.too_short, want.too_short));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb_min_of_window_max_gap NOT OK");
                $finish;
            end
        end
    end

    initial
    begin
        int        phase_items;
        int        n;
        step_row_t row;
        out_beat_t typed_res;
        clear_sequence_state();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[k])
        begin
            row = directed_rows[k];
            if (row.win >= 0)
            begin
                write_window(row.win[WIN_W-1:0]);
            end
            typed_res.min_max_gap = row.exp_gap;
            typed_res.too_short   = row.exp_short;
            send_beat(VAL_W'(row.value), row.last, row.typed, typed_res);
        end

        foreach (phases[p])
        begin
            write_window(phases[p].win < 0 ? WIN_W'($urandom_range(1, 40))
                                           : WIN_W'(phases[p].win));
            idle_mode = phases[p].mode;
            if (phases[p].hold)
            begin
                hold_left = HOLD_CYCLES;
            end
            phase_items = 0;
            while (phase_items < phases[p].items)
            begin
                n = pick_gaps(eff_window(), phases[p].items - phase_items);
                run_sequence(n);
                phase_items += n + 1;
            end
        end

        push <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (END_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("tb_min_of_window_max_gap OK");
        end
        else
        begin
            $display("tb_min_of_window_max_gap NOT OK");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/mwg_pkg.sv
rtl/mwg_front.sv
rtl/mwg_op_fifo.sv
rtl/mwg_back.sv
rtl/min_of_window_max_gap.sv
tb/sv/tb_min_of_window_max_gap.sv
